/* hw/rtl/chip8_instruction_execute_core_assert.svh */
// Assertion macros used by the execute core's controller.
// Depends on nothing; users supply clk and rst_n in scope.
`ifndef CHIP8_INSTRUCTION_EXECUTE_CORE_ASSERT_SVH
`define CHIP8_INSTRUCTION_EXECUTE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define CHIP8_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CHIP8_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CHIP8_ASSERT(label, prop, msg)
`define CHIP8_NEVER(label, expr, msg)
`endif
`endif

/* hw/rtl/chip8_pkg.sv */
// Shared types and codes of the CHIP-8 execute core.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package chip8_pkg;
  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_UNKNOWN = 3'd1;
  localparam logic [2:0] ST_HALT    = 3'd2;
  localparam logic [2:0] ST_CLEAR   = 3'd3;
  localparam logic [2:0] ST_DRAW    = 3'd4;
  localparam logic [2:0] ST_LOAD    = 3'd5;
  localparam logic [2:0] ST_WAITKEY = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_FLAG, S_SEND, S_BCD, S_RD, S_LOAD, S_STORE
  } ctrl_state_t;

  typedef enum logic [1:0] {B_NONE, B_BCD, B_STORE} burst_t;

  typedef struct packed {
    logic capture;
    logic execute;
    logic flag_write;
    logic bcd_next;
    logic st_read;
    logic st_load;
    logic st_next;
  } ctl_cmd_t;

  typedef struct packed {
    logic   need_flag;
    burst_t burst;
    logic   last;
  } dp_stat_t;
endpackage

/* hw/rtl/chip8_ctrl.sv */
// Controller state machine of the CHIP-8 execute core.
// Depends on chip8_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "chip8_instruction_execute_core_assert.svh"
module chip8_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  chip8_pkg::dp_stat_t stat,
  output chip8_pkg::ctl_cmd_t cmd
);
  import chip8_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_EXEC;
      S_EXEC: begin
        if (stat.burst == B_BCD) state_nxt = S_BCD;
        else if (stat.burst == B_STORE) state_nxt = S_RD;
        else if (stat.need_flag) state_nxt = S_FLAG;
        else state_nxt = S_SEND;
      end
      S_FLAG:  state_nxt = S_SEND;
      S_SEND:  if (out_tready) state_nxt = S_IDLE;
      S_BCD:   if (out_tready && stat.last) state_nxt = S_IDLE;
      S_RD:    state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_STORE;
      S_STORE: if (out_tready) state_nxt = stat.last ? S_IDLE : S_RD;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      S_EXEC:  cmd.execute = 1'b1;
      S_FLAG:  cmd.flag_write = 1'b1;
      S_SEND:  out_tvalid = 1'b1;
      S_BCD: begin
        out_tvalid   = 1'b1;
        cmd.bcd_next = out_tready && !stat.last;
      end
      S_RD:    cmd.st_read = 1'b1;
      S_LOAD:  cmd.st_load = 1'b1;
      S_STORE: begin
        out_tvalid  = 1'b1;
        cmd.st_next = out_tready && !stat.last;
      end
      default: ;
    endcase
  end

  `CHIP8_NEVER(a_no_overlap, in_tready && out_tvalid, "accept while a result is pending")
  `CHIP8_ASSERT(a_capture_exec, (state_r == S_IDLE && in_tvalid) |=> (state_r == S_EXEC),
                "accepted item did not reach execute")
  `CHIP8_ASSERT(a_exec_once, (state_r == S_EXEC) |=> (state_r != S_EXEC),
                "execute lasted more than one cycle")
endmodule

/* hw/rtl/chip8_dpath.sv */
// Datapath of the CHIP-8 execute core: register file, stack, PC, I, timers, result.
// Depends on chip8_pkg; driven by chip8_ctrl commands.
`timescale 1ns / 1ps
module chip8_dpath #(
  parameter int STACK_DEPTH = 16,
  parameter int FONT_BASE   = 80
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [39:0]         in_tdata,
  input  chip8_pkg::ctl_cmd_t cmd,
  output chip8_pkg::dp_stat_t stat,
  output logic [2:0]          o_status,
  output logic [11:0]         o_next_pc,
  output logic [3:0]          o_target,
  output logic                o_write_valid,
  output logic [15:0]         o_write_address,
  output logic [7:0]          o_write_data,
  output logic                o_last
);
  import chip8_pkg::*;

  localparam int SpW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [SpW-1:0] SpMax = SpW'(STACK_DEPTH - 1);
  localparam logic [15:0] FontBase = 16'(FONT_BASE);

  logic [15:0] op_r, keys_r;
  logic [7:0]  rnd_r;
  logic [7:0]  va_r, vb_r;
  logic [7:0]  vreg [16];
  logic [11:0] stk [STACK_DEPTH];
  logic [11:0] stk_q_r;
  logic [SpW-1:0] sp_r, sp_dec, sp_inc;
  logic [11:0] pc_r, pc_adv;
  logic [15:0] i_r;
  logic [7:0]  delay_r, sound_r;
  logic        flag_r;
  logic [6:0]  rem_r;
  logic [3:0]  k_r;
  logic [2:0]  status_r;
  logic [3:0]  target_r;
  logic        wv_r, last_r;
  logic [15:0] waddr_r;
  logic [7:0]  wdata_r;

  logic [3:0] hi, x, y, n;
  logic [7:0] nn;
  logic [11:0] nnn;
  assign hi  = op_r[15:12];
  assign x   = op_r[11:8];
  assign y   = op_r[7:4];
  assign n   = op_r[3:0];
  assign nn  = op_r[7:0];
  assign nnn = op_r[11:0];

  assign sp_dec = (sp_r == '0) ? SpMax : sp_r - SpW'(1);
  assign sp_inc = (sp_r == SpMax) ? '0 : sp_r + SpW'(1);
  assign pc_adv = pc_r + 12'd2;

  // Register file reads: port A gives VX, port B gives VY, V0 for BNNN, or Vk in a store.
  logic       rd_en;
  logic [3:0] rd_ax, rd_bx;
  always_comb begin
    rd_en = cmd.capture || cmd.st_read;
    rd_ax = cmd.capture ? in_tdata[11:8] : x;
    if (cmd.st_read) rd_bx = k_r;
    else if (in_tdata[15:12] == 4'hB) rd_bx = 4'h0;
    else rd_bx = in_tdata[7:4];
  end

  logic       v_we;
  logic [3:0] v_wa;
  logic [7:0] v_wd;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      va_r <= vreg[rd_ax];
      vb_r <= vreg[rd_bx];
    end
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) vreg[i] <= 8'd0;
    end else if (v_we) begin
      vreg[v_wa] <= v_wd;
    end
  end

  logic stk_we;
  always_ff @(posedge clk) begin
    if (cmd.capture) stk_q_r <= stk[sp_dec];
    if (stk_we) stk[sp_r] <= pc_adv;
  end

  // Execute decode.
  logic [8:0]  sum9, suba9, subb9;
  logic [7:0]  alu_res;
  logic        alu_flag, alu_ok, alu_fl;
  logic [15:0] i_sum, i_font;
  logic [6:0]  font_off;
  logic        key_bit;
  logic [1:0]  hund;
  logic [7:0]  hrem;

  always_comb begin
    sum9  = {1'b0, va_r} + {1'b0, vb_r};
    suba9 = {1'b0, va_r} - {1'b0, vb_r};
    subb9 = {1'b0, vb_r} - {1'b0, va_r};
    alu_res  = vb_r;
    alu_flag = 1'b0;
    alu_ok   = 1'b1;
    alu_fl   = 1'b0;
    case (n)
      4'h0: alu_res = vb_r;
      4'h1: alu_res = va_r | vb_r;
      4'h2: alu_res = va_r & vb_r;
      4'h3: alu_res = va_r ^ vb_r;
      4'h4: begin alu_res = sum9[7:0]; alu_flag = sum9[8]; alu_fl = 1'b1; end
      4'h5: begin alu_res = suba9[7:0]; alu_flag = !suba9[8]; alu_fl = 1'b1; end
      4'h6: begin alu_res = {1'b0, va_r[7:1]}; alu_flag = va_r[0]; alu_fl = 1'b1; end
      4'h7: begin alu_res = subb9[7:0]; alu_flag = !subb9[8]; alu_fl = 1'b1; end
      4'hE: begin alu_res = {va_r[6:0], 1'b0}; alu_flag = va_r[7]; alu_fl = 1'b1; end
      default: alu_ok = 1'b0;
    endcase
    i_sum    = i_r + {8'd0, va_r};
    font_off = {1'b0, va_r[3:0], 2'b00} + {3'b000, va_r[3:0]};
    i_font   = FontBase + {9'd0, font_off};
    key_bit  = keys_r[va_r[3:0]];
    if (va_r >= 8'd200) hund = 2'd2;
    else if (va_r >= 8'd100) hund = 2'd1;
    else hund = 2'd0;
    hrem = va_r - 8'(hund) * 8'd100;
  end

  always_comb begin
    stat.burst     = B_NONE;
    stat.need_flag = 1'b0;
    stat.last      = last_r;
    if (hi == 4'h8) stat.need_flag = alu_ok && alu_fl;
    if (hi == 4'hF) begin
      if (nn == 8'h33) stat.burst = B_BCD;
      if (nn == 8'h55) stat.burst = B_STORE;
      if (nn == 8'h1E) stat.need_flag = (i_sum[15:12] != 4'h0);
    end
  end

  // Tens digit of a value below 100: (r * 205) >> 11 is exact there.
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [6:0]  ones;
  assign tens_prod = 15'(rem_r) * 15'd205;
  assign tens      = tens_prod[14:11];
  assign ones      = rem_r - 7'(tens * 7'd10);

  logic [11:0] pc_nxt;
  logic [2:0]  st_nxt;
  always_comb begin
    v_we   = 1'b0;
    v_wa   = x;
    v_wd   = 8'd0;
    stk_we = 1'b0;
    pc_nxt = pc_adv;
    st_nxt = ST_DONE;
    if (cmd.execute) begin
      case (hi)
        4'h0: begin
          if (nnn == 12'h000) st_nxt = ST_HALT;
          else if (nnn == 12'h0E0) st_nxt = ST_CLEAR;
          else if (nnn == 12'h0EE) pc_nxt = stk_q_r;
          else st_nxt = ST_UNKNOWN;
        end
        4'h1: pc_nxt = nnn;
        4'h2: begin stk_we = 1'b1; pc_nxt = nnn; end
        4'h3: if (va_r == nn) pc_nxt = pc_adv + 12'd2;
        4'h4: if (va_r != nn) pc_nxt = pc_adv + 12'd2;
        4'h5: begin
          if (n != 4'h0) st_nxt = ST_UNKNOWN;
          else if (va_r == vb_r) pc_nxt = pc_adv + 12'd2;
        end
        4'h6: begin v_we = 1'b1; v_wd = nn; end
        4'h7: begin v_we = 1'b1; v_wd = va_r + nn; end
        4'h8: begin
          if (alu_ok) begin v_we = 1'b1; v_wd = alu_res; end
          else st_nxt = ST_UNKNOWN;
        end
        4'h9: begin
          if (n != 4'h0) st_nxt = ST_UNKNOWN;
          else if (va_r != vb_r) pc_nxt = pc_adv + 12'd2;
        end
        4'hA: ;
        4'hB: pc_nxt = nnn + {4'd0, vb_r};
        4'hC: begin v_we = 1'b1; v_wd = rnd_r & nn; end
        4'hD: st_nxt = ST_DRAW;
        4'hE: begin
          if (nn == 8'h9E) begin
            if (key_bit) pc_nxt = pc_adv + 12'd2;
          end else if (nn == 8'hA1) begin
            if (!key_bit) pc_nxt = pc_adv + 12'd2;
          end else st_nxt = ST_UNKNOWN;
        end
        default: begin
          case (nn)
            8'h07: begin v_we = 1'b1; v_wd = delay_r; end
            8'h15, 8'h18, 8'h29, 8'h1E, 8'h33, 8'h55: ;
            8'h65: st_nxt = ST_LOAD;
            8'h0A: st_nxt = ST_WAITKEY;
            default: st_nxt = ST_UNKNOWN;
          endcase
        end
      endcase
    end else if (cmd.flag_write) begin
      v_we = 1'b1;
      v_wa = 4'hF;
      v_wd = {7'd0, flag_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= 12'h200;
      i_r     <= 16'd0;
      sp_r    <= '0;
      delay_r <= 8'd0;
      sound_r <= 8'd0;
    end else if (cmd.execute) begin
      pc_r <= pc_nxt;
      if (hi == 4'h0 && nnn == 12'h0EE) sp_r <= sp_dec;
      if (hi == 4'h2) sp_r <= sp_inc;
      if (hi == 4'hA) i_r <= {4'd0, nnn};
      if (hi == 4'hF) begin
        case (nn)
          8'h15:   delay_r <= va_r;
          8'h18:   sound_r <= va_r;
          8'h29:   i_r <= i_font;
          8'h1E:   i_r <= i_sum;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_tdata[15:0];
      keys_r <= in_tdata[31:16];
      rnd_r  <= in_tdata[39:32];
    end
    if (cmd.execute) begin
      flag_r   <= (hi == 4'h8) ? alu_flag : 1'b1;
      status_r <= st_nxt;
      target_r <= (st_nxt == ST_LOAD || st_nxt == ST_WAITKEY) ? x : 4'd0;
      k_r      <= 4'd0;
      if (stat.burst == B_BCD) begin
        wv_r    <= 1'b1;
        waddr_r <= i_r;
        wdata_r <= {6'd0, hund};
        rem_r   <= hrem[6:0];
        last_r  <= 1'b0;
      end else begin
        wv_r    <= 1'b0;
        waddr_r <= 16'd0;
        wdata_r <= 8'd0;
        last_r  <= 1'b1;
      end
    end
    if (cmd.bcd_next) begin
      waddr_r <= waddr_r + 16'd1;
      if (waddr_r == i_r) begin
        wdata_r <= {4'd0, tens};
        rem_r   <= ones;
      end else begin
        wdata_r <= {1'b0, rem_r};
        last_r  <= 1'b1;
      end
    end
    if (cmd.st_load) begin
      wv_r    <= 1'b1;
      waddr_r <= i_r + {12'd0, k_r};
      wdata_r <= vb_r;
      last_r  <= (k_r == x);
    end
    if (cmd.st_next) k_r <= k_r + 4'd1;
  end

  assign o_status        = status_r;
  assign o_next_pc       = pc_r;
  assign o_target        = target_r;
  assign o_write_valid   = wv_r;
  assign o_write_address = waddr_r;
  assign o_write_data    = wdata_r;
  assign o_last          = last_r;
endmodule

/* hw/rtl/chip8_instruction_execute_core.sv */
// CHIP-8 instruction execute core: the controller and datapath joined at the top.
// Depends on chip8_pkg, chip8_ctrl and chip8_dpath.
//
// Usage: the input channel takes one fetched instruction per item together with the
// held-key mask and a random byte. The result channel returns one status item per
// instruction, or a burst of memory-write items for BCD and register-store, the last
// one flagged on out_tlast. Every result carries the PC for the next fetch.
// Timing: an item is taken while idle and executed in the next; a single result is
// offered from the send state after execute, or after a flag state when VF must also
// be written, since the register file has one write port. The core takes the next item
// in the cycle after the result is taken. A BCD burst shows one digit per cycle while
// out_tready is high; a register store reads and loads each byte before offering it.
// Reset: the V registers, I, the timers and the stack pointer clear to zero and the
// PC resets to 0x200. The return stack has no reset. When out_tready is low the
// result holds and no new item is taken.
`timescale 1ns / 1ps
module chip8_instruction_execute_core #(
  parameter int STACK_DEPTH = 16,
  parameter int FONT_BASE   = 80
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // instruction_word, keys_held, random_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // next_pc, target_register, write_address, write_data
  output logic [3:0]  out_tuser,  // status, write_valid
  output logic        out_tlast
);
  import chip8_pkg::*;

  ctl_cmd_t    cmd;
  dp_stat_t    stat;
  logic [2:0]  status;
  logic [11:0] next_pc;
  logic [3:0]  target;
  logic        wv;
  logic [15:0] waddr;
  logic [7:0]  wdata;

  chip8_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .stat(stat), .cmd(cmd)
  );

  chip8_dpath #(.STACK_DEPTH(STACK_DEPTH), .FONT_BASE(FONT_BASE)) u_dpath (
    .clk(clk), .rst_n(rst_n), .in_tdata(in_tdata), .cmd(cmd), .stat(stat),
    .o_status(status), .o_next_pc(next_pc), .o_target(target), .o_write_valid(wv),
    .o_write_address(waddr), .o_write_data(wdata), .o_last(out_tlast)
  );

  assign out_tdata = {wdata, waddr, target, next_pc};
  assign out_tuser = {wv, status};
endmodule
